// ----- rtl/core/ers_pkg.sv -----
// Shared widths, register codes and sideband types of the epipolar residual scorer.
package ers_pkg;

   // Field and register widths.
   localparam int COEF_W       = 21;
   localparam int POINT_W      = 16;
   localparam int ROW_W        = 3 * COEF_W;
   localparam int MODE_W       = 2;
   localparam int SCORE_W      = 32;
   localparam int SCORE_FRAC_W = 16;
   localparam int CSR_INDEX_W  = 2;

   // Default fixed-point formats.
   localparam int DEF_COEF_FRAC_BITS  = 16;
   localparam int DEF_POINT_FRAC_BITS = 4;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_SCORE_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_ZERO   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_ONE    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_TWO    = 2'd3;

   // Score modes.
   localparam logic [MODE_W-1:0] MODE_ALGEBRAIC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAX_SQUARED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SUM_DIST    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESET       = MODE_MAX_SQUARED;

   // Internal datapath widths.
   localparam int PROD_W       = COEF_W + POINT_W;
   localparam int LINE_W       = PROD_W + 2;
   localparam int MAG_W        = LINE_W - 1;
   localparam int HALF_W       = (MAG_W + 1) / 2;
   localparam int SQP_W        = 2 * HALF_W;
   localparam int RP_W         = LINE_W + POINT_W;
   localparam int RESID_W      = RP_W + 2;
   localparam int ABS_W        = RESID_W - 1;
   localparam int ABS_HALF_W   = ABS_W / 2;
   localparam int APP_W        = 2 * ABS_HALF_W;
   localparam int NORM_W       = 2 * MAG_W + 1;
   localparam int SQ_W         = 2 * ABS_W;
   localparam int SCALED_W     = SQ_W + SCORE_FRAC_W;
   localparam int QUO_W        = 64;
   localparam int DIV_EXTRA_W  = SCORE_FRAC_W;
   localparam int ROOT_W       = QUO_W / 2;
   localparam int FRONT_STAGES = 7;

   // Sideband that travels with each request through the long pipelines.
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic               sat;
      logic [SCORE_W-1:0] score;
   } ers_tag_type;

endpackage

// ----- rtl/core/epipolar_residual_score.sv -----
// Stages from request acceptance to rsp_valid: 7 front, 64 divider, 32 root, 1 out.
// Throughput: one request per cycle while the skid register is empty; the divider resolves one
// quotient bit per stage and the root unit one root bit per stage, all stages advancing together.
// A result register plus a skid register let requests flow while a result waits to be taken.
// Reset (synchronous) clears all valid bits and loads the register defaults; no clearing pass.
module epipolar_residual_score #(
   parameter int COEF_FRAC_BITS  = ers_pkg::DEF_COEF_FRAC_BITS,
   parameter int POINT_FRAC_BITS = ers_pkg::DEF_POINT_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [ers_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ers_pkg::ROW_W-1:0]            csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [ers_pkg::POINT_W-1:0]   req_first_x,
   input  logic signed [ers_pkg::POINT_W-1:0]   req_first_y,
   input  logic signed [ers_pkg::POINT_W-1:0]   req_second_x,
   input  logic signed [ers_pkg::POINT_W-1:0]   req_second_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ers_pkg::SCORE_W-1:0]          rsp_error_score,
   output logic                                 rsp_saturated
);
   import ers_pkg::*;

   localparam logic [ROW_W-1:0] ROW_TWO_RESET = ROW_W'(1) << (2 * COEF_W + COEF_FRAC_BITS);

   logic [MODE_W-1:0]       mode_ff;
   logic [2:0][ROW_W-1:0]   row_ff;

   logic                    adv;
   logic                    front_valid;
   logic [SCALED_W-1:0]     front_num;
   logic [1:0][NORM_W-1:0]  front_den;
   ers_tag_type             front_tag;
   logic                    div_valid;
   logic [1:0][QUO_W-1:0]   div_quo;
   ers_tag_type             div_tag;
   ers_tag_type             root_tag_in;
   logic                    root_valid;
   logic [1:0][ROOT_W-1:0]  root_val;
   ers_tag_type             root_tag;

   logic [SCORE_W-1:0]      final_score;
   logic                    final_sat;
   logic                    out_valid_ff, skid_valid_ff;
   logic [SCORE_W-1:0]      out_score_ff, skid_score_ff;
   logic                    out_sat_ff, skid_sat_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         row_ff[0] <= '0;
         row_ff[1] <= '0;
         row_ff[2] <= ROW_TWO_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SCORE_MODE: mode_ff   <= csr_write_data[MODE_W-1:0];
            CSR_ROW_ZERO:   row_ff[0] <= csr_write_data;
            CSR_ROW_ONE:    row_ff[1] <= csr_write_data;
            CSR_ROW_TWO:    row_ff[2] <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // The whole pipeline moves while the skid register is empty.
   assign adv       = ~skid_valid_ff;
   assign req_ready = adv;

   ers_front #(
      .COEF_FRAC_BITS  (COEF_FRAC_BITS),
      .POINT_FRAC_BITS (POINT_FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .cfg_mode    (mode_ff),
      .cfg_rows    (row_ff),
      .in_valid    (req_valid),
      .in_first_x  (req_first_x),
      .in_first_y  (req_first_y),
      .in_second_x (req_second_x),
      .in_second_y (req_second_y),
      .out_valid   (front_valid),
      .out_num     (front_num),
      .out_den     (front_den),
      .out_tag     (front_tag)
   );

   ers_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (front_valid),
      .in_num    (front_num),
      .in_den    (front_den),
      .in_tag    (front_tag),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_tag   (div_tag)
   );

   // In the max squared distance mode the integer part of the first quotient is the score.
   always_comb begin
      root_tag_in = div_tag;
      if (div_tag.mode == MODE_MAX_SQUARED) begin
         root_tag_in.score = div_quo[0][DIV_EXTRA_W +: SCORE_W];
      end
   end

   ers_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (div_valid),
      .in_rad    (div_quo),
      .in_tag    (root_tag_in),
      .out_valid (root_valid),
      .out_root  (root_val),
      .out_tag   (root_tag)
   );

   // Final score: the summed distances add the two roots, other modes pass the sideband on.
   always_comb begin
      logic [SCORE_W:0] sum;
      logic             sat;
      logic [SCORE_W-1:0] score;
      sum = {1'b0, root_val[0]} + {1'b0, root_val[1]};
      if (root_tag.mode == MODE_SUM_DIST) begin
         sat   = root_tag.sat | sum[SCORE_W];
         score = sum[SCORE_W-1:0];
      end else begin
         sat   = root_tag.sat;
         score = root_tag.score;
      end
      final_sat   = sat;
      final_score = sat ? '1 : score;
   end

   // Result register with a skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (root_valid) begin
         if (~out_valid_ff || rsp_ready) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_score_ff <= skid_score_ff;
            out_sat_ff   <= skid_sat_ff;
         end
      end else if (root_valid) begin
         if (~out_valid_ff || rsp_ready) begin
            out_score_ff <= final_score;
            out_sat_ff   <= final_sat;
         end else begin
            skid_score_ff <= final_score;
            skid_sat_ff   <= final_sat;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_error_score = out_score_ff;
   assign rsp_saturated   = out_sat_ff;

endmodule

// ----- rtl/core/ers_front.sv -----
// Seven-stage front end: epipolar lines, residual, line norms and scaled squared residual.
module ers_front #(
   parameter int COEF_FRAC_BITS  = ers_pkg::DEF_COEF_FRAC_BITS,
   parameter int POINT_FRAC_BITS = ers_pkg::DEF_POINT_FRAC_BITS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       en,
   input  logic [ers_pkg::MODE_W-1:0]                 cfg_mode,
   input  logic [2:0][ers_pkg::ROW_W-1:0]             cfg_rows,
   input  logic                                       in_valid,
   input  logic signed [ers_pkg::POINT_W-1:0]         in_first_x,
   input  logic signed [ers_pkg::POINT_W-1:0]         in_first_y,
   input  logic signed [ers_pkg::POINT_W-1:0]         in_second_x,
   input  logic signed [ers_pkg::POINT_W-1:0]         in_second_y,
   output logic                                       out_valid,
   output logic [ers_pkg::SCALED_W-1:0]               out_num,
   output logic [1:0][ers_pkg::NORM_W-1:0]            out_den,
   output ers_pkg::ers_tag_type                       out_tag
);
   import ers_pkg::*;

   // Shifts that bring the squared residual over a line norm into Q16.16, and the doubled residual in mode 0.
   localparam int SCALE_SH = SCORE_FRAC_W - 2 * POINT_FRAC_BITS;
   localparam int ALG_SH   = COEF_FRAC_BITS + 2 * POINT_FRAC_BITS - SCORE_FRAC_W;
   localparam int ALG_SHL  = (ALG_SH < 0) ? -ALG_SH : 0;
   localparam int ALG_SHR  = (ALG_SH > 0) ? ALG_SH : 0;
   localparam int ALG_W    = ABS_W + 1 + ALG_SHL;

   logic [FRONT_STAGES-1:0] vld_ff;

   // Matrix coefficients, decoded from the rows.
   logic signed [COEF_W-1:0] m [3][3];

   logic signed [PROD_W-1:0]  a_s1_ff [3][2];
   logic signed [PROD_W-1:0]  b_s1_ff [2][2];
   logic signed [PROD_W-1:0]  a_s1_in [3][2];
   logic signed [PROD_W-1:0]  b_s1_in [2][2];
   logic signed [POINT_W-1:0] qx_s1_ff, qy_s1_ff;

   logic signed [LINE_W-1:0]  l1_s2_ff [3];
   logic signed [LINE_W-1:0]  l2_s2_ff [2];
   logic signed [LINE_W-1:0]  l1_s2_in [3];
   logic signed [LINE_W-1:0]  l2_s2_in [2];
   logic signed [POINT_W-1:0] qx_s2_ff, qy_s2_ff;

   logic signed [RP_W-1:0]   rp_s3_ff [2];
   logic signed [RP_W-1:0]   rp_s3_in [2];
   logic signed [LINE_W-1:0] lz_s3_ff;
   logic [SQP_W-1:0]         sqp_s3_ff [4][3];
   logic [SQP_W-1:0]         sqp_s3_in [4][3];

   logic signed [RESID_W-1:0] resid_s4_ff, resid_s4_in;
   logic [NORM_W-1:0]         n_s4_ff [2];
   logic [NORM_W-1:0]         n_s4_in [2];

   logic [ABS_W-1:0]          abs_s5_ff, abs_s5_in;
   logic [APP_W-1:0]          app_s5_ff [3];
   logic [APP_W-1:0]          app_s5_in [3];
   logic [1:0][NORM_W-1:0]    den_s5_ff, den_s5_in;

   logic [SCALED_W-1:0]       scaled_s6_ff, scaled_s6_in;
   logic [1:0][NORM_W-1:0]    den_s6_ff;
   logic [SCORE_W-1:0]        alg_s6_ff, alg_s6_in;
   logic                      alg_sat_s6_ff, alg_sat_s6_in;

   logic [SCALED_W-1:0]       num_s7_ff;
   logic [1:0][NORM_W-1:0]    den_s7_ff;
   ers_tag_type               tag_s7_ff, tag_s7_in;

   // Coefficient decode; column 0 sits in the low bits of each row.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            m[i][j] = signed'(cfg_rows[i][COEF_W*j +: COEF_W]);
         end
      end
   end

   // Valid bits travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[FRONT_STAGES-2:0], in_valid};
      end
   end

   // Stage 1: coefficient by point products.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_s1_in[i][0] = PROD_W'(m[i][0]) * PROD_W'(in_first_x);
         a_s1_in[i][1] = PROD_W'(m[i][1]) * PROD_W'(in_first_y);
      end
      for (int j = 0; j < 2; j++) begin
         b_s1_in[j][0] = PROD_W'(m[0][j]) * PROD_W'(in_second_x);
         b_s1_in[j][1] = PROD_W'(m[1][j]) * PROD_W'(in_second_y);
      end
   end

   // Stage 2: sums that form the two epipolar lines.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         l1_s2_in[i] = LINE_W'(a_s1_ff[i][0]) + LINE_W'(a_s1_ff[i][1])
                     + (LINE_W'(m[i][2]) <<< POINT_FRAC_BITS);
      end
      for (int j = 0; j < 2; j++) begin
         l2_s2_in[j] = LINE_W'(b_s1_ff[j][0]) + LINE_W'(b_s1_ff[j][1])
                     + (LINE_W'(m[2][j]) <<< POINT_FRAC_BITS);
      end
   end

   // Stage 3: residual products and split squares of the line normals.
   always_comb begin
      logic signed [LINE_W-1:0] line [4];
      logic [LINE_W-1:0]        neg;
      logic [MAG_W-1:0]         mag;
      logic [HALF_W-1:0]        hi, lo;
      line[0] = l1_s2_ff[0];
      line[1] = l1_s2_ff[1];
      line[2] = l2_s2_ff[0];
      line[3] = l2_s2_ff[1];
      rp_s3_in[0] = RP_W'(l1_s2_ff[0]) * RP_W'(qx_s2_ff);
      rp_s3_in[1] = RP_W'(l1_s2_ff[1]) * RP_W'(qy_s2_ff);
      for (int k = 0; k < 4; k++) begin
         neg = line[k][LINE_W-1] ? -line[k] : line[k];
         mag = neg[MAG_W-1:0];
         hi  = HALF_W'(mag >> HALF_W);
         lo  = mag[HALF_W-1:0];
         sqp_s3_in[k][0] = SQP_W'(hi) * SQP_W'(hi);
         sqp_s3_in[k][1] = SQP_W'(hi) * SQP_W'(lo);
         sqp_s3_in[k][2] = SQP_W'(lo) * SQP_W'(lo);
      end
   end

   // Stage 4: residual sum and the squared line normals.
   always_comb begin
      logic [NORM_W-1:0] sq [4];
      resid_s4_in = RESID_W'(rp_s3_ff[0]) + RESID_W'(rp_s3_ff[1])
                  + (RESID_W'(lz_s3_ff) <<< POINT_FRAC_BITS);
      for (int k = 0; k < 4; k++) begin
         sq[k] = (NORM_W'(sqp_s3_ff[k][0]) << (2 * HALF_W))
               + (NORM_W'(sqp_s3_ff[k][1]) << (HALF_W + 1))
               + NORM_W'(sqp_s3_ff[k][2]);
      end
      n_s4_in[0] = sq[0] + sq[1];
      n_s4_in[1] = sq[2] + sq[3];
   end

   // Stage 5: residual magnitude, its split square, and the divisor choice.
   always_comb begin
      logic [RESID_W-1:0]    neg;
      logic [ABS_HALF_W-1:0] hi, lo;
      logic [NORM_W-1:0]     nmin;
      neg       = resid_s4_ff[RESID_W-1] ? -resid_s4_ff : resid_s4_ff;
      abs_s5_in = neg[ABS_W-1:0];
      hi        = ABS_HALF_W'(abs_s5_in >> ABS_HALF_W);
      lo        = abs_s5_in[ABS_HALF_W-1:0];
      app_s5_in[0] = APP_W'(hi) * APP_W'(hi);
      app_s5_in[1] = APP_W'(hi) * APP_W'(lo);
      app_s5_in[2] = APP_W'(lo) * APP_W'(lo);
      nmin = (n_s4_ff[0] >= n_s4_ff[1]) ? n_s4_ff[1] : n_s4_ff[0];
      den_s5_in[0] = (cfg_mode == MODE_MAX_SQUARED) ? nmin : n_s4_ff[0];
      den_s5_in[1] = n_s4_ff[1];
   end

   // Stage 6: squared residual scaled so its quotient by a line norm is Q16.16, and the algebraic score.
   always_comb begin
      logic [SQ_W-1:0]  sq;
      logic [ALG_W-1:0] alg;
      sq = (SQ_W'(app_s5_ff[0]) << (2 * ABS_HALF_W))
         + (SQ_W'(app_s5_ff[1]) << (ABS_HALF_W + 1))
         + SQ_W'(app_s5_ff[2]);
      scaled_s6_in  = SCALED_W'(sq) << SCALE_SH;
      alg           = (ALG_W'({abs_s5_ff, 1'b0}) << ALG_SHL) >> ALG_SHR;
      alg_s6_in     = alg[SCORE_W-1:0];
      alg_sat_s6_in = |alg[ALG_W-1:SCORE_W];
   end

   // Stage 7: saturation checks that keep the quotients in range.
   always_comb begin
      logic zero_a, zero_b, big_a, big_b, over_min;
      zero_a   = (den_s6_ff[0] == '0);
      zero_b   = (den_s6_ff[1] == '0);
      over_min = (scaled_s6_ff >= (SCALED_W'(den_s6_ff[0]) << SCORE_W));
      big_a    = (scaled_s6_ff >= (SCALED_W'(den_s6_ff[0]) << (QUO_W - DIV_EXTRA_W)));
      big_b    = (scaled_s6_ff >= (SCALED_W'(den_s6_ff[1]) << (QUO_W - DIV_EXTRA_W)));
      tag_s7_in.mode  = cfg_mode;
      tag_s7_in.score = '0;
      case (cfg_mode)
         MODE_ALGEBRAIC: begin
            tag_s7_in.sat   = alg_sat_s6_ff;
            tag_s7_in.score = alg_s6_ff;
         end
         MODE_MAX_SQUARED: begin
            tag_s7_in.sat = zero_a | over_min;
         end
         MODE_SUM_DIST: begin
            tag_s7_in.sat = zero_a | zero_b | big_a | big_b;
         end
         default: begin
            tag_s7_in.sat = 1'b1;
         end
      endcase
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (en) begin
         a_s1_ff       <= a_s1_in;
         b_s1_ff       <= b_s1_in;
         qx_s1_ff      <= in_second_x;
         qy_s1_ff      <= in_second_y;
         l1_s2_ff      <= l1_s2_in;
         l2_s2_ff      <= l2_s2_in;
         qx_s2_ff      <= qx_s1_ff;
         qy_s2_ff      <= qy_s1_ff;
         rp_s3_ff      <= rp_s3_in;
         lz_s3_ff      <= l1_s2_ff[2];
         sqp_s3_ff     <= sqp_s3_in;
         resid_s4_ff   <= resid_s4_in;
         n_s4_ff       <= n_s4_in;
         abs_s5_ff     <= abs_s5_in;
         app_s5_ff     <= app_s5_in;
         den_s5_ff     <= den_s5_in;
         scaled_s6_ff  <= scaled_s6_in;
         den_s6_ff     <= den_s5_ff;
         alg_s6_ff     <= alg_s6_in;
         alg_sat_s6_ff <= alg_sat_s6_in;
         num_s7_ff     <= scaled_s6_ff;
         den_s7_ff     <= den_s6_ff;
         tag_s7_ff     <= tag_s7_in;
      end
   end

   assign out_valid = vld_ff[FRONT_STAGES-1];
   assign out_num   = num_s7_ff;
   assign out_den   = den_s7_ff;
   assign out_tag   = tag_s7_ff;

endmodule

// ----- rtl/core/ers_divider.sv -----
// Pipelined restoring divider: two lanes share a numerator, one quotient bit per stage.
module ers_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [ers_pkg::SCALED_W-1:0]        in_num,
   input  logic [1:0][ers_pkg::NORM_W-1:0]     in_den,
   input  ers_pkg::ers_tag_type                in_tag,
   output logic                                out_valid,
   output logic [1:0][ers_pkg::QUO_W-1:0]      out_quo,
   output ers_pkg::ers_tag_type                out_tag
);
   import ers_pkg::*;

   // Per stage: partial remainder, and a word that shifts out dividend bits
   // and shifts in quotient bits.
   logic [QUO_W-1:0]        vld_ff;
   logic [1:0][NORM_W-1:0]  rem_ff  [QUO_W];
   logic [1:0][QUO_W-1:0]   bits_ff [QUO_W];
   logic [1:0][NORM_W-1:0]  den_ff  [QUO_W];
   ers_tag_type             tag_ff  [QUO_W];

   logic [1:0][NORM_W-1:0]  src_rem  [QUO_W];
   logic [1:0][QUO_W-1:0]   src_bits [QUO_W];
   logic [1:0][NORM_W-1:0]  src_den  [QUO_W];
   ers_tag_type             src_tag  [QUO_W];
   logic [1:0][NORM_W-1:0]  rem_in   [QUO_W];
   logic [1:0][QUO_W-1:0]   bits_in  [QUO_W];

   // Stage inputs: the first stage takes the request, the rest the stage before.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         src_rem[0][l]  = in_num[QUO_W-DIV_EXTRA_W +: NORM_W];
         src_bits[0][l] = {in_num[QUO_W-DIV_EXTRA_W-1:0], DIV_EXTRA_W'(0)};
      end
      src_den[0] = in_den;
      src_tag[0] = in_tag;
      for (int s = 1; s < QUO_W; s++) begin
         src_rem[s]  = rem_ff[s-1];
         src_bits[s] = bits_ff[s-1];
         src_den[s]  = den_ff[s-1];
         src_tag[s]  = tag_ff[s-1];
      end
   end

   // One trial subtraction per stage and lane.
   always_comb begin
      logic [NORM_W:0]   trial;
      logic [NORM_W+1:0] diff;
      for (int s = 0; s < QUO_W; s++) begin
         for (int l = 0; l < 2; l++) begin
            trial = {src_rem[s][l], src_bits[s][l][QUO_W-1]};
            diff  = {1'b0, trial} - {2'b00, src_den[s][l]};
            rem_in[s][l]  = diff[NORM_W+1] ? trial[NORM_W-1:0] : diff[NORM_W-1:0];
            bits_in[s][l] = {src_bits[s][l][QUO_W-2:0], ~diff[NORM_W+1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QUO_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < QUO_W; s++) begin
            rem_ff[s]  <= rem_in[s];
            bits_ff[s] <= bits_in[s];
            den_ff[s]  <= src_den[s];
            tag_ff[s]  <= src_tag[s];
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = bits_ff[QUO_W-1];
   assign out_tag   = tag_ff[QUO_W-1];

endmodule

// ----- rtl/core/ers_sqrt.sv -----
// Pipelined integer square root of two lanes, one root bit per stage.
module ers_sqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [1:0][ers_pkg::QUO_W-1:0]      in_rad,
   input  ers_pkg::ers_tag_type                in_tag,
   output logic                                out_valid,
   output logic [1:0][ers_pkg::ROOT_W-1:0]     out_root,
   output ers_pkg::ers_tag_type                out_tag
);
   import ers_pkg::*;

   localparam int REM_W = ROOT_W + 2;

   logic [ROOT_W-1:0]       vld_ff;
   logic [1:0][QUO_W-1:0]   rad_ff  [ROOT_W];
   logic [1:0][REM_W-1:0]   rem_ff  [ROOT_W];
   logic [1:0][ROOT_W-1:0]  root_ff [ROOT_W];
   ers_tag_type             tag_ff  [ROOT_W];

   logic [1:0][QUO_W-1:0]   src_rad  [ROOT_W];
   logic [1:0][REM_W-1:0]   src_rem  [ROOT_W];
   logic [1:0][ROOT_W-1:0]  src_root [ROOT_W];
   ers_tag_type             src_tag  [ROOT_W];
   logic [1:0][QUO_W-1:0]   rad_in   [ROOT_W];
   logic [1:0][REM_W-1:0]   rem_in   [ROOT_W];
   logic [1:0][ROOT_W-1:0]  root_in  [ROOT_W];

   // Stage inputs.
   always_comb begin
      src_rad[0]  = in_rad;
      src_rem[0]  = '0;
      src_root[0] = '0;
      src_tag[0]  = in_tag;
      for (int s = 1; s < ROOT_W; s++) begin
         src_rad[s]  = rad_ff[s-1];
         src_rem[s]  = rem_ff[s-1];
         src_root[s] = root_ff[s-1];
         src_tag[s]  = tag_ff[s-1];
      end
   end

   // Bring down two radicand bits and try the next root bit.
   always_comb begin
      logic [REM_W+1:0] trial;
      logic [REM_W+2:0] diff;
      for (int s = 0; s < ROOT_W; s++) begin
         for (int l = 0; l < 2; l++) begin
            trial = {src_rem[s][l], src_rad[s][l][QUO_W-1 -: 2]};
            diff  = {1'b0, trial} - (REM_W+3)'({src_root[s][l], 2'b01});
            rad_in[s][l] = {src_rad[s][l][QUO_W-3:0], 2'b00};
            if (diff[REM_W+2]) begin
               rem_in[s][l]  = trial[REM_W-1:0];
               root_in[s][l] = {src_root[s][l][ROOT_W-2:0], 1'b0};
            end else begin
               rem_in[s][l]  = diff[REM_W-1:0];
               root_in[s][l] = {src_root[s][l][ROOT_W-2:0], 1'b1};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ROOT_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < ROOT_W; s++) begin
            rad_ff[s]  <= rad_in[s];
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            tag_ff[s]  <= src_tag[s];
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

// ----- tb/sv/epipolar_residual_score_tb.sv -----
// Self-checking testbench for the epipolar residual scorer, with its own score predictor.
module epipolar_residual_score_tb;
   import ers_pkg::*;

   localparam int COEF_FRAC  = 16;
   localparam int POINT_FRAC = 4;
   localparam int CLK_HALF   = 4;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic signed [POINT_W-1:0] fx;
      logic signed [POINT_W-1:0] fy;
      logic signed [POINT_W-1:0] sx;
      logic signed [POINT_W-1:0] sy;
   } point_pair_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               sat;
   } score_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [ROW_W-1:0]          csr_write_data;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [POINT_W-1:0] req_first_x;
   logic signed [POINT_W-1:0] req_first_y;
   logic signed [POINT_W-1:0] req_second_x;
   logic signed [POINT_W-1:0] req_second_y;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [SCORE_W-1:0]        rsp_error_score;
   logic                      rsp_saturated;

   // Shadow copy of the configuration registers.
   logic [MODE_W-1:0] mode_shadow;
   logic [ROW_W-1:0]  row_shadow [3];

   score_type pending_scores [$];
   int     error_count;
   bit     quiet;
   bit     stall_pending;
   int     stall_left;
   int     idle_cycles;

   epipolar_residual_score dut (.*);

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Integer square root, one root bit per step from the top.
   function automatic logic [31:0] int_root(logic [63:0] v);
      logic [31:0] root;
      logic [31:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (32'd1 << i);
         if ({32'd0, trial} * {32'd0, trial} <= v) root = trial;
      end
      return root;
   endfunction

   // Predicts the score of one request from the shadow registers.
   function automatic score_type predict_score(point_pair_type p);
      longint signed m [3][3];
      longint signed px, py, qx, qy, l1x, l1y, l1z, l2x, l2y, resid;
      longint signed one;
      logic [63:0]  absr, twice;
      logic [127:0] a, b, c, d, n1, n2, nmin;
      logic [159:0] scaled, q1, q2;
      logic [33:0]  total;
      score_type res;
      one = longint'(1) << POINT_FRAC;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            m[i][j] = longint'($signed(row_shadow[i][COEF_W*j +: COEF_W]));
      px = p.fx; py = p.fy; qx = p.sx; qy = p.sy;
      l1x = m[0][0] * px + m[0][1] * py + m[0][2] * one;
      l1y = m[1][0] * px + m[1][1] * py + m[1][2] * one;
      l1z = m[2][0] * px + m[2][1] * py + m[2][2] * one;
      l2x = m[0][0] * qx + m[1][0] * qy + m[2][0] * one;
      l2y = m[0][1] * qx + m[1][1] * qy + m[2][1] * one;
      resid = l1x * qx + l1y * qy + l1z * one;
      absr = (resid < 0) ? 64'(-resid) : 64'(resid);
      a = (l1x < 0) ? 128'(64'(-l1x)) : 128'(64'(l1x));
      b = (l1y < 0) ? 128'(64'(-l1y)) : 128'(64'(l1y));
      c = (l2x < 0) ? 128'(64'(-l2x)) : 128'(64'(l2x));
      d = (l2y < 0) ? 128'(64'(-l2y)) : 128'(64'(l2y));
      n1 = a * a + b * b;
      n2 = c * c + d * d;
      scaled = (160'(absr) * 160'(absr)) << (16 - 2 * POINT_FRAC);
      res.score = '0;
      res.sat = 1'b0;
      case (mode_shadow)
         MODE_ALGEBRAIC: begin
            twice = absr << 1;
            twice = twice >> (COEF_FRAC + 2 * POINT_FRAC - 16);
            if (twice > 64'hFFFF_FFFF) res.sat = 1'b1;
            else res.score = twice[31:0];
         end
         MODE_MAX_SQUARED: begin
            nmin = (n1 >= n2) ? n2 : n1;
            if (nmin == 0 || scaled >= (160'(nmin) << 32)) res.sat = 1'b1;
            else begin
               q1 = scaled / 160'(nmin);
               res.score = q1[31:0];
            end
         end
         MODE_SUM_DIST: begin
            if (n1 == 0 || n2 == 0 || scaled >= (160'(n1) << 48) ||
                scaled >= (160'(n2) << 48)) begin
               res.sat = 1'b1;
            end else begin
               q1 = (scaled << 16) / 160'(n1);
               q2 = (scaled << 16) / 160'(n2);
               total = 34'(int_root(q1[63:0])) + 34'(int_root(q2[63:0]));
               if (total > 34'hFFFF_FFFF) res.sat = 1'b1;
               else res.score = total[31:0];
            end
         end
         default: res.sat = 1'b1;
      endcase
      if (res.sat) res.score = '1;
      return res;
   endfunction

   // Random value with a random number of significant bits, sign extended.
   function automatic logic [COEF_W-1:0] rand_coef();
      int bits;
      logic [COEF_W-1:0] v;
      bits = $urandom_range(COEF_W, 1);
      v = COEF_W'($urandom);
      v = v & ((COEF_W'(1) << bits) - 1);
      if (v[bits-1]) v = v | ~((COEF_W'(1) << bits) - 1);
      return v;
   endfunction

   function automatic logic signed [POINT_W-1:0] rand_point();
      int bits;
      logic [POINT_W-1:0] v;
      bits = $urandom_range(POINT_W, 1);
      v = POINT_W'($urandom);
      v = v & ((POINT_W'(1) << bits) - 1);
      if (v[bits-1]) v = v | ~((POINT_W'(1) << bits) - 1);
      return v;
   endfunction

   // Register write, only ever issued while nothing is in flight.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [ROW_W-1:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_en = 1'b0;
      if (idx == CSR_SCORE_MODE) mode_shadow = data[MODE_W-1:0];
      else row_shadow[idx - 1] = data;
   endtask

   task automatic load_matrix(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                              logic [ROW_W-1:0] r2);
      write_csr(CSR_ROW_ZERO, r0);
      write_csr(CSR_ROW_ONE, r1);
      write_csr(CSR_ROW_TWO, r2);
   endtask

   task automatic load_random_matrix();
      logic [ROW_W-1:0] r [3];
      for (int i = 0; i < 3; i++) r[i] = {rand_coef(), rand_coef(), rand_coef()};
      load_matrix(r[0], r[1], r[2]);
   endtask

   // Waits until every predicted score has been returned and the pipe is empty.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_scores.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Offers one request and returns once it has been accepted.
   task automatic send_pair(point_pair_type p);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 9) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_first_x = p.fx;
      req_first_y = p.fy;
      req_second_x = p.sx;
      req_second_y = p.sy;
      do @(posedge clock); while (!req_ready);
      pending_scores.push_back(predict_score(p));
   endtask

   task automatic send_random_pair();
      point_pair_type p;
      if ($urandom_range(9) == 0) begin
         p = {$urandom, $urandom};
      end else begin
         p.fx = rand_point(); p.fy = rand_point();
         p.sx = rand_point(); p.sy = rand_point();
      end
      send_pair(p);
   endtask

   // Reset values: mode 1 with both line normals zero, so every score saturates.
   task automatic test_reset_defaults();
      send_pair({16'sd16, 16'sd32, -16'sd48, 16'sd5});
      send_pair('0);
      drain();
   endtask

   // Extreme points and coefficients under every mode, including the unused one.
   task automatic test_directed_extremes();
      logic [COEF_W-1:0] cmax, cmin, cone;
      cmax = {1'b0, {(COEF_W-1){1'b1}}};
      cmin = {1'b1, {(COEF_W-1){1'b0}}};
      cone = COEF_W'(1) << COEF_FRAC;
      for (int md = 0; md < 4; md++) begin
         write_csr(CSR_SCORE_MODE, ROW_W'(md));
         // Zero diagonal with unit and extreme coefficients off it, under extreme and small points.
         load_matrix({cmin, cone, 21'd0}, {21'd0, 21'd0, cone}, {21'd0, cmax, cmin});
         send_pair({16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
         send_pair({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
         send_pair({16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
         send_pair({16'sd16, 16'sd0, 16'sd0, 16'sd16});
         drain();
         // All coefficients at their extremes.
         load_matrix({cmax, cmin, cmax}, {cmin, cmax, cmin}, {cmax, cmax, cmax});
         send_pair({16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF});
         send_pair({16'sd1, -16'sd1, 16'sd0, 16'sd0});
         drain();
      end
      // Sum of distances on a sparse F: only entries (0,2), (1,2) and (2,0) are set.
      write_csr(CSR_SCORE_MODE, ROW_W'(MODE_SUM_DIST));
      load_matrix({cone, 21'd0, 21'd0}, {cone, 21'd0, 21'd0}, {21'd0, 21'd0, cone});
      send_pair({16'sd40, 16'sd80, 16'sd3, 16'sd9});
      drain();
   endtask

   // Random matrices and pairs under each mode, with one phase free of idling.
   task automatic test_random_scoring();
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_SCORE_MODE, ROW_W'(ph == 7 ? 3 : ph % 3));
         load_random_matrix();
         quiet = (ph == 4);
         for (int k = 0; k < 65; k++) send_random_pair();
         drain();
         quiet = 1'b0;
      end
   endtask

   // Receiver holds off long enough that the pipe fills and stalls its input.
   task automatic test_output_backpressure();
      write_csr(CSR_SCORE_MODE, ROW_W'(MODE_SUM_DIST));
      load_random_matrix();
      stall_pending = 1'b1;
      for (int k = 0; k < 160; k++) send_random_pair();
      drain();
   endtask

   // Result ready, with random idling and a long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_pending) begin
            stall_pending = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = quiet || ($urandom_range(99) >= 9);
         end
      end
   end

   // Compares each returned score with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_scores.size() == 0) begin
            $display("%0t: unexpected result score=%h sat=%b", $time,
                     rsp_error_score, rsp_saturated);
            error_count++;
         end else begin
            score_type want;
            want = pending_scores.pop_front();
            if (rsp_error_score !== want.score) begin
               $display("%0t: error_score expected %h actual %h", $time,
                        want.score, rsp_error_score);
               error_count++;
            end
            if (rsp_saturated !== want.sat) begin
               $display("%0t: saturated expected %b actual %b", $time,
                        want.sat, rsp_saturated);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("epipolar_residual_score: mismatch");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
      quiet = 1'b0;
      stall_pending = 1'b0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_first_x = '0;
      req_first_y = '0;
      req_second_x = '0;
      req_second_y = '0;
      mode_shadow = MODE_RESET;
      row_shadow[0] = '0;
      row_shadow[1] = '0;
      row_shadow[2] = ROW_W'(1) << (2 * COEF_W + COEF_FRAC);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_directed_extremes();
      test_random_scoring();
      test_output_backpressure();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_scores.size() == 0) begin
         $display("epipolar_residual_score: match");
      end else begin
         $display("epipolar_residual_score: mismatch");
      end
      $finish;
   end

endmodule
